// ----- src/rrfit_pkg.sv -----
package rrfit_pkg;

    localparam int SIDE_BITS          = 16;
    localparam int STEPS_PER_RADIAN   = 1000;
    localparam int TRIG_FRACTION_BITS = 16;

    localparam int TRIG_W = TRIG_FRACTION_BITS + 1;
    localparam int PROD_W = SIDE_BITS + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int LIM_W  = SIDE_BITS + TRIG_FRACTION_BITS;
    localparam int AREA_W = 2 * SIDE_BITS;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam int              TAYLOR_TERMS = 12;

    localparam int SWEEP_COUNT =
        int'((longint'(STEPS_PER_RADIAN) * HALF_PI_Q30) >> 30);
    localparam int ADDR_W = $clog2(SWEEP_COUNT);

    // angle step as a rounded reciprocal, exact for every swept angle
    localparam longint unsigned HALF_STEP   = longint'(STEPS_PER_RADIAN / 2);
    localparam int              THETA_SHIFT = 62;
    localparam longint unsigned THETA_RCP   =
        ((64'd1 << THETA_SHIFT) + longint'(STEPS_PER_RADIAN) - 64'd1)
        / longint'(STEPS_PER_RADIAN);

    // reciprocals of the factorial factors of the sine and cosine series terms
    localparam int              RCP_SHIFT = 50;
    localparam longint unsigned RCP_ONE   = 64'd1 << RCP_SHIFT;
    localparam longint unsigned SIN_RCP [1:TAYLOR_TERMS] = '{
        (RCP_ONE + 64'd5) / 64'd6,     (RCP_ONE + 64'd19) / 64'd20,
        (RCP_ONE + 64'd41) / 64'd42,   (RCP_ONE + 64'd71) / 64'd72,
        (RCP_ONE + 64'd109) / 64'd110, (RCP_ONE + 64'd155) / 64'd156,
        (RCP_ONE + 64'd209) / 64'd210, (RCP_ONE + 64'd271) / 64'd272,
        (RCP_ONE + 64'd341) / 64'd342, (RCP_ONE + 64'd419) / 64'd420,
        (RCP_ONE + 64'd505) / 64'd506, (RCP_ONE + 64'd599) / 64'd600};
    localparam longint unsigned COS_RCP [1:TAYLOR_TERMS] = '{
        (RCP_ONE + 64'd1) / 64'd2,     (RCP_ONE + 64'd11) / 64'd12,
        (RCP_ONE + 64'd29) / 64'd30,   (RCP_ONE + 64'd55) / 64'd56,
        (RCP_ONE + 64'd89) / 64'd90,   (RCP_ONE + 64'd131) / 64'd132,
        (RCP_ONE + 64'd181) / 64'd182, (RCP_ONE + 64'd239) / 64'd240,
        (RCP_ONE + 64'd305) / 64'd306, (RCP_ONE + 64'd379) / 64'd380,
        (RCP_ONE + 64'd461) / 64'd462, (RCP_ONE + 64'd551) / 64'd552};

    typedef logic [2*TRIG_W-1:0] t_trig_pair;
    typedef t_trig_pair t_trig_table [SWEEP_COUNT];

    function automatic longint unsigned round_trig(longint v);
        longint          c;
        longint unsigned u;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > longint'(Q30_ONE)) begin
            c = longint'(Q30_ONE);
        end
        u = longint'(c);
        return (u + (64'd1 << (29 - TRIG_FRACTION_BITS))) >> (30 - TRIG_FRACTION_BITS);
    endfunction

    function automatic t_trig_table build_trig_table();
        t_trig_table     tab;
        longint unsigned theta;
        longint unsigned st;
        longint unsigned ct;
        longint          ssum;
        longint          csum;
        longint unsigned sn;
        longint unsigned cs;
        logic [127:0]    wide;
        for (int i = 1; i <= SWEEP_COUNT; i++) begin
            wide  = 128'((longint'(i) << 30) + HALF_STEP) * 128'(THETA_RCP);
            theta = 64'(wide >> THETA_SHIFT);
            st   = theta;
            ct   = Q30_ONE;
            ssum = longint'(theta);
            csum = longint'(Q30_ONE);
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                st   = (st * theta) >> 30;
                wide = 128'((st * theta) >> 30) * 128'(SIN_RCP[k]);
                st   = 64'(wide >> RCP_SHIFT);
                ct   = (ct * theta) >> 30;
                wide = 128'((ct * theta) >> 30) * 128'(COS_RCP[k]);
                ct   = 64'(wide >> RCP_SHIFT);
                if ((k % 2) == 1) begin
                    ssum = ssum - longint'(st);
                    csum = csum - longint'(ct);
                end else begin
                    ssum = ssum + longint'(st);
                    csum = csum + longint'(ct);
                end
            end
            sn = round_trig(ssum);
            cs = round_trig(csum);
            tab[i-1] = {sn[TRIG_W-1:0], cs[TRIG_W-1:0]};
        end
        return tab;
    endfunction

    localparam t_trig_table TRIG_TABLE = build_trig_table();

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_CHECK,
        S_START,
        S_SWEEP,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic area;
        logic start;
        logic issue;
        logic set_fits;
        logic fits_val;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic area_ok;
        logic direct_fit;
        logic last_addr;
        logic busy;
        logic hit;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- src/rotated_rectangle_fit_test.sv -----
// sequence: load, area products, check, then done when the area test or the unturned test decides;
// otherwise start, then the angle sweep (one table angle per cycle, 1570 angles,
// three-stage table read / multiply / compare pipeline), drain and done
// throughput: one item at a time, next beat accepted the cycle after the result is loaded
// into the output register; an output stall holds the result in the done state
// reset: synchronous active-low i_rst_n clears the controller and the output valid
module rotated_rectangle_fit_test (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_container_side_one,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_container_side_two,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_box_side_one,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_box_side_two,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_fits
);

    rrfit_pkg::t_dp_cmd  cmd;
    rrfit_pkg::t_dp_stat stat;

    rrfit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rrfit_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_container_side_one (i_container_side_one),
        .i_container_side_two (i_container_side_two),
        .i_box_side_one       (i_box_side_one),
        .i_box_side_two       (i_box_side_two),
        .i_out_stall          (i_out_stall),
        .o_stat               (stat),
        .o_out_valid          (o_out_valid),
        .o_fits               (o_fits)
    );

endmodule

// ----- src/rrfit_ctrl.sv -----
module rrfit_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rrfit_pkg::t_dp_stat i_stat,
    output rrfit_pkg::t_dp_cmd  o_cmd,
    output logic                o_in_stall
);

    rrfit_pkg::t_state r_state;
    rrfit_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rrfit_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            rrfit_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rrfit_pkg::S_AREA;
                end
            end
            rrfit_pkg::S_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = rrfit_pkg::S_CHECK;
            end
            rrfit_pkg::S_CHECK: begin
                if (!i_stat.area_ok) begin
                    o_cmd.set_fits = 1'b1;
                    o_cmd.fits_val = 1'b0;
                    n_state        = rrfit_pkg::S_DONE;
                end else if (i_stat.direct_fit) begin
                    o_cmd.set_fits = 1'b1;
                    o_cmd.fits_val = 1'b1;
                    n_state        = rrfit_pkg::S_DONE;
                end else begin
                    n_state = rrfit_pkg::S_START;
                end
            end
            rrfit_pkg::S_START: begin
                o_cmd.start = 1'b1;
                n_state     = rrfit_pkg::S_SWEEP;
            end
            rrfit_pkg::S_SWEEP: begin
                if (i_stat.hit) begin
                    o_cmd.set_fits = 1'b1;
                    o_cmd.fits_val = 1'b1;
                    n_state        = rrfit_pkg::S_DONE;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_stat.last_addr) begin
                        n_state = rrfit_pkg::S_DRAIN;
                    end
                end
            end
            rrfit_pkg::S_DRAIN: begin
                if (i_stat.hit) begin
                    o_cmd.set_fits = 1'b1;
                    o_cmd.fits_val = 1'b1;
                    n_state        = rrfit_pkg::S_DONE;
                end else if (!i_stat.busy) begin
                    o_cmd.set_fits = 1'b1;
                    o_cmd.fits_val = 1'b0;
                    n_state        = rrfit_pkg::S_DONE;
                end
            end
            rrfit_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rrfit_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrfit_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/rrfit_dp.sv -----
module rrfit_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rrfit_pkg::t_dp_cmd              i_cmd,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_container_side_one,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_container_side_two,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_box_side_one,
    input  logic [rrfit_pkg::SIDE_BITS-1:0] i_box_side_two,
    input  logic                            i_out_stall,
    output rrfit_pkg::t_dp_stat             o_stat,
    output logic                            o_out_valid,
    output logic                            o_fits
);

    logic [rrfit_pkg::SIDE_BITS-1:0] r_a;
    logic [rrfit_pkg::SIDE_BITS-1:0] r_b;
    logic [rrfit_pkg::SIDE_BITS-1:0] r_x;
    logic [rrfit_pkg::SIDE_BITS-1:0] r_y;
    logic [rrfit_pkg::AREA_W-1:0]    r_area_c;
    logic [rrfit_pkg::AREA_W-1:0]    r_area_b;
    logic                            r_direct;

    logic [rrfit_pkg::ADDR_W-1:0]    r_addr;
    rrfit_pkg::t_trig_pair           r_trig;
    logic                            r_v1;
    logic [rrfit_pkg::PROD_W-1:0]    r_p_ys;
    logic [rrfit_pkg::PROD_W-1:0]    r_p_xc;
    logic [rrfit_pkg::PROD_W-1:0]    r_p_xs;
    logic [rrfit_pkg::PROD_W-1:0]    r_p_yc;
    logic                            r_v2;
    logic                            r_hit;

    logic                            r_fits;
    logic                            r_out_valid;
    logic                            r_out_fits;

    logic [rrfit_pkg::TRIG_W-1:0]    sin_val;
    logic [rrfit_pkg::TRIG_W-1:0]    cos_val;
    logic [rrfit_pkg::SUM_W-1:0]     first_side;
    logic [rrfit_pkg::SUM_W-1:0]     second_side;
    logic [rrfit_pkg::LIM_W-1:0]     lim_a;
    logic [rrfit_pkg::LIM_W-1:0]     lim_b;
    logic                            angle_fit;

    assign sin_val = r_trig[2*rrfit_pkg::TRIG_W-1:rrfit_pkg::TRIG_W];
    assign cos_val = r_trig[rrfit_pkg::TRIG_W-1:0];

    // long side first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_container_side_one < i_container_side_two) begin
                r_a <= i_container_side_two;
                r_b <= i_container_side_one;
            end else begin
                r_a <= i_container_side_one;
                r_b <= i_container_side_two;
            end
            if (i_box_side_one < i_box_side_two) begin
                r_x <= i_box_side_two;
                r_y <= i_box_side_one;
            end else begin
                r_x <= i_box_side_one;
                r_y <= i_box_side_two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.area) begin
            r_area_c <= rrfit_pkg::AREA_W'(r_a) * rrfit_pkg::AREA_W'(r_b);
            r_area_b <= rrfit_pkg::AREA_W'(r_x) * rrfit_pkg::AREA_W'(r_y);
            r_direct <= (r_x <= r_a) && (r_y <= r_b);
        end
    end

    // sweep: table read, products, bounding box compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + rrfit_pkg::ADDR_W'(1);
        end
        if (i_cmd.issue) begin
            r_trig <= rrfit_pkg::TRIG_TABLE[r_addr];
        end
        r_p_ys <= rrfit_pkg::PROD_W'(r_y) * rrfit_pkg::PROD_W'(sin_val);
        r_p_xc <= rrfit_pkg::PROD_W'(r_x) * rrfit_pkg::PROD_W'(cos_val);
        r_p_xs <= rrfit_pkg::PROD_W'(r_x) * rrfit_pkg::PROD_W'(sin_val);
        r_p_yc <= rrfit_pkg::PROD_W'(r_y) * rrfit_pkg::PROD_W'(cos_val);
    end

    assign first_side  = rrfit_pkg::SUM_W'(r_p_ys) + rrfit_pkg::SUM_W'(r_p_xc);
    assign second_side = rrfit_pkg::SUM_W'(r_p_xs) + rrfit_pkg::SUM_W'(r_p_yc);
    assign lim_a       = {r_a, {rrfit_pkg::TRIG_FRACTION_BITS{1'b0}}};
    assign lim_b       = {r_b, {rrfit_pkg::TRIG_FRACTION_BITS{1'b0}}};
    assign angle_fit   = (first_side <= rrfit_pkg::SUM_W'(lim_a)) &&
                         (second_side <= rrfit_pkg::SUM_W'(lim_b));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_cmd.start) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            r_v1  <= i_cmd.issue;
            r_v2  <= r_v1;
            r_hit <= r_hit | (r_v2 & angle_fit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_fits) begin
            r_fits <= i_cmd.fits_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fits <= r_fits;
        end
    end

    assign o_stat.area_ok    = r_area_c >= r_area_b;
    assign o_stat.direct_fit = r_direct;
    assign o_stat.last_addr  = r_addr == rrfit_pkg::ADDR_W'(rrfit_pkg::SWEEP_COUNT - 1);
    assign o_stat.busy       = r_v1 | r_v2;
    assign o_stat.hit        = r_hit;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_fits      = r_out_fits;

endmodule

// ----- test/rotated_rectangle_fit_test_tb.sv -----
`timescale 1ns / 1ps

module rotated_rectangle_fit_test_tb;

    localparam int SW   = rrfit_pkg::SIDE_BITS;
    localparam int FRAC = rrfit_pkg::TRIG_FRACTION_BITS;
    localparam int STEPS = rrfit_pkg::STEPS_PER_RADIAN;
    localparam longint unsigned HALF_PI_FIXED = 64'd1686629713;
    localparam longint unsigned ONE_FIXED     = 64'd1 << 30;
    localparam int SERIES_TERMS = 12;
    localparam int ANGLE_COUNT  = int'((longint'(STEPS) * HALF_PI_FIXED) >> 30);
    localparam int SIDE_MAX = (1 << SW) - 1;

    typedef logic [SW-1:0] t_side;

    logic  i_clk                = 1'b0;
    logic  i_rst_n              = 1'b0;
    logic  i_in_valid           = 1'b0;
    t_side i_container_side_one = '0;
    t_side i_container_side_two = '0;
    t_side i_box_side_one       = '0;
    t_side i_box_side_two       = '0;
    logic  i_out_stall          = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    logic  o_fits;

    rotated_rectangle_fit_test u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_container_side_one (i_container_side_one),
        .i_container_side_two (i_container_side_two),
        .i_box_side_one       (i_box_side_one),
        .i_box_side_two       (i_box_side_two),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_fits               (o_fits)
    );

    always #1 i_clk = ~i_clk;

    longint unsigned angle_sin [ANGLE_COUNT];
    longint unsigned angle_cos [ANGLE_COUNT];

    bit fit_expected [$];
    int fail_count   = 0;
    int item_count   = 0;
    int result_count = 0;
    int yes_count    = 0;
    bit idle_on      = 1'b1;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    function automatic longint unsigned trig_round(longint v);
        longint c;
        c = v;
        if (c < 0) begin
            c = 0;
        end
        if (c > longint'(ONE_FIXED)) begin
            c = longint'(ONE_FIXED);
        end
        return (longint'(c) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
    endfunction

    function automatic void build_angle_table();
        longint unsigned theta;
        longint unsigned st;
        longint unsigned ct;
        longint unsigned k;
        longint          ssum;
        longint          csum;
        for (int i = 1; i <= ANGLE_COUNT; i++) begin
            theta = ((longint'(i) << 30) + longint'(STEPS / 2)) / longint'(STEPS);
            st    = theta;
            ct    = ONE_FIXED;
            ssum  = longint'(theta);
            csum  = longint'(ONE_FIXED);
            for (k = 1; k <= SERIES_TERMS; k++) begin
                st = (st * theta) >> 30;
                st = ((st * theta) >> 30) / ((2 * k) * (2 * k + 1));
                ct = (ct * theta) >> 30;
                ct = ((ct * theta) >> 30) / ((2 * k - 1) * (2 * k));
                if (k[0]) begin
                    ssum = ssum - longint'(st);
                    csum = csum - longint'(ct);
                end else begin
                    ssum = ssum + longint'(st);
                    csum = csum + longint'(ct);
                end
            end
            angle_sin[i-1] = trig_round(ssum);
            angle_cos[i-1] = trig_round(csum);
        end
    endfunction

    function automatic bit fit_predict(t_side cs1, t_side cs2, t_side bs1, t_side bs2);
        longint unsigned a;
        longint unsigned b;
        longint unsigned x;
        longint unsigned y;
        longint unsigned t;
        longint unsigned lim_a;
        longint unsigned lim_b;
        longint unsigned f;
        longint unsigned s;
        a = cs1;
        b = cs2;
        x = bs1;
        y = bs2;
        if (a < b) begin
            t = a; a = b; b = t;
        end
        if (x < y) begin
            t = x; x = y; y = t;
        end
        if (a * b < x * y) begin
            return 1'b0;
        end
        if (x <= a && y <= b) begin
            return 1'b1;
        end
        lim_a = a << FRAC;
        lim_b = b << FRAC;
        for (int i = 0; i < ANGLE_COUNT; i++) begin
            f = y * angle_sin[i] + x * angle_cos[i];
            s = x * angle_sin[i] + y * angle_cos[i];
            if (f <= lim_a && s <= lim_b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // input beats queue a prediction, output beats are checked against the oldest one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                fit_expected.push_back(fit_predict(i_container_side_one, i_container_side_two,
                                                   i_box_side_one, i_box_side_two));
                item_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (o_fits) begin
                    yes_count++;
                end
                if (fit_expected.size() == 0) begin
                    $error("unexpected result beat: fits %0d", o_fits);
                    fail_count++;
                end else if (o_fits !== fit_expected[0]) begin
                    $error("fits: expected %0d, actual %0d", fit_expected[0], o_fits);
                    fail_count++;
                    void'(fit_expected.pop_front());
                end else begin
                    void'(fit_expected.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 2500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 38);
        end
    end

    task automatic send_item(input t_side cs1, input t_side cs2,
                             input t_side bs1, input t_side bs2);
        while (idle_on && $urandom_range(99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_container_side_one <= cs1;
        i_container_side_two <= cs2;
        i_box_side_one       <= bs1;
        i_box_side_two       <= bs2;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (fit_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_item();
        int    kind;
        int    a;
        int    b;
        int    x;
        int    y;
        t_side t;
        t_side cs1;
        t_side cs2;
        t_side bs1;
        t_side bs2;
        kind = $urandom_range(99);
        if (kind < 40) begin
            // thin box at least as long as the container, may fit across the diagonal
            a = $urandom_range(16, SIDE_MAX);
            b = $urandom_range(1, a);
            x = a + $urandom_range(1, b / 2 + 1);
            if (x > SIDE_MAX) begin
                x = SIDE_MAX;
            end
            y = $urandom_range(0, b / 4);
        end else if (kind < 55) begin
            a = $urandom_range(SIDE_MAX);
            b = $urandom_range(SIDE_MAX);
            x = $urandom_range(SIDE_MAX);
            y = $urandom_range(SIDE_MAX);
        end else if (kind < 70) begin
            a = $urandom_range(SIDE_MAX);
            b = $urandom_range(SIDE_MAX);
            x = $urandom_range(0, a);
            y = $urandom_range(0, b);
        end else if (kind < 80) begin
            a = $urandom_range(0, 4000);
            b = $urandom_range(0, 4000);
            x = $urandom_range(4000, SIDE_MAX);
            y = $urandom_range(4000, SIDE_MAX);
        end else if (kind < 90) begin
            a = $urandom_range(15);
            b = $urandom_range(15);
            x = $urandom_range(15);
            y = $urandom_range(15);
        end else begin
            a = $urandom_range(255);
            b = $urandom_range(255);
            x = $urandom_range(255);
            y = x + $urandom_range(0, 3);
        end
        cs1 = t_side'(a);
        cs2 = t_side'(b);
        bs1 = t_side'(x);
        bs2 = t_side'(y);
        if ($urandom_range(1)) begin
            t = cs1; cs1 = cs2; cs2 = t;
        end
        if ($urandom_range(1)) begin
            t = bs1; bs1 = bs2; bs2 = t;
        end
        send_item(cs1, cs2, bs1, bs2);
    endtask

    task automatic test_directed();
        send_item(16'd0, 16'd0, 16'd0, 16'd0);
        send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(16'hffff, 16'h0001, 16'hffff, 16'hffff);
        send_item(16'd0, 16'd0, 16'd5, 16'd0);
        send_item(16'd10, 16'd0, 16'd0, 16'd5);
        send_item(16'd0, 16'd0, 16'd3, 16'd3);
        send_item(16'd4, 16'd9, 16'd6, 16'd6);
        send_item(16'd9, 16'd4, 16'd6, 16'd6);
        send_item(16'd100, 16'd20, 16'd101, 16'd5);
        send_item(16'd20, 16'd100, 16'd5, 16'd101);
        send_item(16'd100, 16'd10, 16'd150, 16'd1);
        send_item(16'd100, 16'd100, 16'd141, 16'd1);
        send_item(16'd100, 16'd100, 16'd142, 16'd0);
        send_item(16'hffff, 16'hffff, 16'hffff, 16'h0000);
        send_item(16'hfff0, 16'h8000, 16'hffff, 16'h0100);
        send_item(16'h0001, 16'hffff, 16'h0000, 16'hffff);
        send_item(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        send_item(16'h00ff, 16'hff00, 16'hff01, 16'h0001);
        send_item(16'd1000, 16'd1, 16'd999, 16'd2);
        send_item(16'd3, 16'd3, 16'd4, 16'd1);
        wait_drained();
    endtask

    task automatic test_random_mix();
        repeat (250) begin
            send_random_item();
        end
    endtask

    task automatic test_long_hold();
        hold_req = 1'b1;
        repeat (10) begin
            send_random_item();
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (50) begin
            send_random_item();
        end
        idle_on = 1'b1;
    endtask

    task automatic test_drain_pause();
        repeat (4) begin
            repeat (10) begin
                send_random_item();
            end
            wait_drained();
        end
    endtask

    initial begin
        build_angle_table();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_mix();
        test_long_hold();
        test_back_to_back();
        test_drain_pause();
        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d input beats and %0d result beats (%0d fit, %0d no fit)",
                 item_count, result_count, yes_count, result_count - yes_count);
        $display("directed extremes, diagonal sweeps, area rejects, long output hold, drains");
        if (fail_count == 0) begin
            $display("rotated_rectangle_fit_test: match");
        end else begin
            $display("rotated_rectangle_fit_test: mismatch");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("rotated_rectangle_fit_test: mismatch");
        $finish;
    end

endmodule
